### design/ckr_pkg.sv
// Shared types, constants and bit-shuffle functions for the canonical k-mer recoder.
// Used by every module of the block; has no dependencies of its own.

package ckr_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned KLEN_W = 6;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd63;
    // From this length on, the high word is recoded too.
    localparam logic [KLEN_W-1:0] KLEN_HALF  = 6'd32;
    localparam logic [WORD_W-1:0] ALT_MASK   = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word hi;
        t_word lo;
    } t_kmer;

    // Swap codes 2 and 3 in every 2-bit base: flip the low bit where the high bit is set.
    function automatic t_word recode_word(input t_word w);
        return w ^ ((w & ALT_MASK) >> 1);
    endfunction

    // Reverse the order of the 2-bit bases within a word.
    function automatic t_word reverse_groups(input t_word w);
        t_word r;
        for (int i = 0; i < WORD_W / 2; i++) begin
            r[2*i +: 2] = w[(WORD_W - 2 - 2*i) +: 2];
        end
        return r;
    endfunction

endpackage

### design/ckr_revcomp.sv
// Recoding and reverse complement of one k-mer (combinational).
// Depends on ckr_pkg for the word types and the shuffle functions.

module ckr_revcomp (
    input  ckr_pkg::t_kmer                     i_raw,
    input  logic [ckr_pkg::KLEN_W-1:0]         i_kmer_length,
    output ckr_pkg::t_kmer                     o_fwd,
    output ckr_pkg::t_kmer                     o_rev
);

    ckr_pkg::t_kmer rc_full;
    logic [7:0]     shamt;

    always_comb begin
        o_fwd.lo = ckr_pkg::recode_word(i_raw.lo);
        o_fwd.hi = (i_kmer_length >= ckr_pkg::KLEN_HALF) ? ckr_pkg::recode_word(i_raw.hi)
                                                         : i_raw.hi;
    end

    // Complement, reverse each word and swap the words; then align base 0 at the bottom.
    always_comb begin
        rc_full.hi = ckr_pkg::reverse_groups(o_fwd.lo ^ ckr_pkg::ALT_MASK);
        rc_full.lo = ckr_pkg::reverse_groups(o_fwd.hi ^ ckr_pkg::ALT_MASK);
    end

    // A length of zero gives a shift of 128, which clears the whole value.
    assign shamt = 8'd128 - {1'b0, i_kmer_length, 1'b0};
    assign o_rev = rc_full >> shamt;

endmodule

### design/ckr_select.sv
// Picks the canonical k-mer: the smaller of forward and reverse complement.
// Depends on ckr_pkg for the k-mer type.

module ckr_select (
    input  ckr_pkg::t_kmer i_fwd,
    input  ckr_pkg::t_kmer i_rev,
    output ckr_pkg::t_kmer o_canon,
    output logic           o_took_reverse
);

    // Unsigned 128-bit compare, high word first; the forward k-mer wins a tie.
    assign o_took_reverse = (i_rev < i_fwd);
    assign o_canon        = o_took_reverse ? i_rev : i_fwd;

endmodule

### design/canonical_kmer_recode_top.sv
// Top level of the canonical k-mer recoder: input register, shuffle logic, result register.
// Depends on ckr_pkg, ckr_revcomp and ckr_select.
//
// Usage:
//   A k-mer beat (i_raw_high, i_raw_low) is taken at a rising edge with start high
//   and busy low. busy is always low, so a new beat can be taken every cycle.
//   Each beat gives exactly one result beat, shown for one cycle with
//   o_result_valid high: the recoded words, the canonical words and o_took_reverse.
//   A taken beat passes through the input register and then the result register,
//   which drives the outputs. Throughput is one beat per cycle, set by
//   the single stage of shuffle and 128-bit compare between the two registers.
//   The receiver cannot stall; results are never held back.
//   Configuration: i_cfg_we writes the 6-bit k-mer length from i_cfg_wdata at the
//   next edge. Write it only while no beat is in flight.
//   Reset (i_rst_n low, synchronous) empties both stages and sets the length to 63.

module canonical_kmer_recode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ckr_pkg::WORD_W-1:0]    i_raw_high,
    input  logic [ckr_pkg::WORD_W-1:0]    i_raw_low,
    input  logic                          i_cfg_we,
    input  logic [ckr_pkg::KLEN_W-1:0]    i_cfg_wdata,
    output logic                          o_result_valid,
    output logic [ckr_pkg::WORD_W-1:0]    o_recoded_high,
    output logic [ckr_pkg::WORD_W-1:0]    o_recoded_low,
    output logic [ckr_pkg::WORD_W-1:0]    o_canonical_high,
    output logic [ckr_pkg::WORD_W-1:0]    o_canonical_low,
    output logic                          o_took_reverse
);

    logic [ckr_pkg::KLEN_W-1:0] r_kmer_length;
    logic                       r_in_valid;
    ckr_pkg::t_kmer             r_raw;
    logic                       r_out_valid;
    ckr_pkg::t_kmer             r_recoded;
    ckr_pkg::t_kmer             r_canon;
    logic                       r_took_reverse;

    ckr_pkg::t_kmer             n_fwd;
    ckr_pkg::t_kmer             n_rev;
    ckr_pkg::t_kmer             n_canon;
    logic                       n_took_reverse;
    logic                       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= ckr_pkg::KLEN_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_kmer_length <= i_cfg_wdata;
            end
            r_in_valid  <= accept;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw.hi <= i_raw_high;
            r_raw.lo <= i_raw_low;
        end
        if (r_in_valid) begin
            r_recoded      <= n_fwd;
            r_canon        <= n_canon;
            r_took_reverse <= n_took_reverse;
        end
    end

    ckr_revcomp u_revcomp (
        .i_raw         (r_raw),
        .i_kmer_length (r_kmer_length),
        .o_fwd         (n_fwd),
        .o_rev         (n_rev)
    );

    ckr_select u_select (
        .i_fwd          (n_fwd),
        .i_rev          (n_rev),
        .o_canon        (n_canon),
        .o_took_reverse (n_took_reverse)
    );

    assign o_result_valid   = r_out_valid;
    assign o_recoded_high   = r_recoded.hi;
    assign o_recoded_low    = r_recoded.lo;
    assign o_canonical_high = r_canon.hi;
    assign o_canonical_low  = r_canon.lo;
    assign o_took_reverse   = r_took_reverse;

endmodule

### design/ckr_checker.sv
// Port-level checks for the canonical k-mer recoder, bound to the top level.
// Depends on ckr_pkg for widths and on canonical_kmer_recode_top for the bind.

module ckr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [ckr_pkg::WORD_W-1:0]    i_raw_high,
    input  logic [ckr_pkg::WORD_W-1:0]    i_raw_low,
    input  logic                          i_cfg_we,
    input  logic [ckr_pkg::KLEN_W-1:0]    i_cfg_wdata,
    input  logic                          o_result_valid,
    input  logic [ckr_pkg::WORD_W-1:0]    o_recoded_high,
    input  logic [ckr_pkg::WORD_W-1:0]    o_recoded_low,
    input  logic [ckr_pkg::WORD_W-1:0]    o_canonical_high,
    input  logic [ckr_pkg::WORD_W-1:0]    o_canonical_low,
    input  logic                          o_took_reverse
);

    // Every accepted beat yields a result once it has passed the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("accepted beat produced no result");

    // No result appears unless a beat was accepted and passed through the input register.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> ##1 !o_result_valid)
        else $error("result without an accepted beat");

    // The reverse complement is chosen only when it is strictly smaller.
    a_reverse_smaller: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_took_reverse) |->
            ({o_canonical_high, o_canonical_low} < {o_recoded_high, o_recoded_low}))
        else $error("reverse chosen but not smaller");

    // Otherwise the canonical k-mer is the forward k-mer itself.
    a_forward_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_took_reverse) |->
            (o_canonical_high == o_recoded_high && o_canonical_low == o_recoded_low))
        else $error("forward kept but canonical differs");

endmodule

bind canonical_kmer_recode_top ckr_checker u_ckr_checker (.*);

### tb/kmer_recode_checker.sv
// Checker for the canonical k-mer recoder: tracks the k-mer length register, predicts each
// result beat from the accepted k-mer beats and compares it field by field.
// Depends on ckr_pkg for the word type and the reset length.
`timescale 1ns / 1ps

module kmer_recode_checker
    import ckr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_word             i_raw_high,
    input  t_word             i_raw_low,
    input  logic              i_cfg_we,
    input  logic [KLEN_W-1:0] i_cfg_wdata,
    input  logic              i_result_valid,
    input  t_word             i_recoded_high,
    input  t_word             i_recoded_low,
    input  t_word             i_canonical_high,
    input  t_word             i_canonical_low,
    input  logic              i_took_reverse,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        t_word rec_hi;
        t_word rec_lo;
        t_word can_hi;
        t_word can_lo;
        logic  took_rev;
    } t_kmer_result;

    t_kmer_result      pending_canon[$];
    logic [KLEN_W-1:0] kmer_len;
    int                mismatches;

    // Works base by base on the 128-bit k-mer, base 0 in the lowest two bits.
    function automatic t_kmer_result predict_canonical(input t_word hi, input t_word lo,
                                                       input logic [KLEN_W-1:0] k);
        logic [127:0] fwd;
        logic [127:0] comp;
        logic [127:0] rc;
        t_kmer_result r;
        fwd = {hi, lo};
        // The high word is left as it is for short k-mers.
        for (int b = 0; b < 64; b++) begin
            if ((b < 32 || k >= KLEN_HALF) && fwd[2*b+1]) begin
                fwd[2*b] = ~fwd[2*b];
            end
        end
        // With A0 C1 T2 G3 the complement of a base is the base XOR 2.
        comp = fwd ^ {64{2'b10}};
        for (int b = 0; b < 64; b++) begin
            rc[2*b +: 2] = comp[2*(63-b) +: 2];
        end
        rc = rc >> (128 - 2 * int'(k));
        r.rec_hi   = fwd[127:64];
        r.rec_lo   = fwd[63:0];
        r.took_rev = (rc < fwd);
        r.can_hi   = r.took_rev ? rc[127:64] : fwd[127:64];
        r.can_lo   = r.took_rev ? rc[63:0] : fwd[63:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_kmer_result exp_r;
        t_kmer_result got_r;
        if (!i_rst_n) begin
            kmer_len = KLEN_RESET;
            pending_canon.delete();
            mismatches = 0;
        end else begin
            if (i_result_valid) begin
                got_r = '{i_recoded_high, i_recoded_low, i_canonical_high, i_canonical_low,
                          i_took_reverse};
                if (pending_canon.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: ERROR: result beat with none expected: rec %h_%h", $time,
                                 got_r.rec_hi, got_r.rec_lo);
                    end
                end else begin
                    exp_r = pending_canon.pop_front();
                    if (got_r !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: ERROR: result mismatch", $time);
                            $display("  recoded   exp %h_%h got %h_%h", exp_r.rec_hi,
                                     exp_r.rec_lo, got_r.rec_hi, got_r.rec_lo);
                            $display("  canonical exp %h_%h got %h_%h", exp_r.can_hi,
                                     exp_r.can_lo, got_r.can_hi, got_r.can_lo);
                            $display("  reverse   exp %b got %b", exp_r.took_rev,
                                     got_r.took_rev);
                        end
                    end
                end
            end
            // A beat is predicted with the length that holds at its own edge.
            if (i_start && !i_busy) begin
                pending_canon.push_back(predict_canonical(i_raw_high, i_raw_low, kmer_len));
            end
            if (i_cfg_we) begin
                kmer_len = i_cfg_wdata;
            end
        end
        o_errors  <= mismatches;
        o_pending <= pending_canon.size();
    end

endmodule

### tb/canonical_kmer_recode_top_tb.sv
// Testbench top for the canonical k-mer recoder: clock, reset, k-mer beats and length writes.
// Depends on ckr_pkg, canonical_kmer_recode_top and kmer_recode_checker.
`timescale 1ns / 1ps

module canonical_kmer_recode_top_tb;
    import ckr_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_word             i_raw_high;
    t_word             i_raw_low;
    logic              i_cfg_we;
    logic [KLEN_W-1:0] i_cfg_wdata;
    logic              o_result_valid;
    t_word             o_recoded_high;
    t_word             o_recoded_low;
    t_word             o_canonical_high;
    t_word             o_canonical_low;
    logic              o_took_reverse;
    int                errors;
    int                pending;
    int unsigned       idle_pct;

    canonical_kmer_recode_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_raw_high       (i_raw_high),
        .i_raw_low        (i_raw_low),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_valid   (o_result_valid),
        .o_recoded_high   (o_recoded_high),
        .o_recoded_low    (o_recoded_low),
        .o_canonical_high (o_canonical_high),
        .o_canonical_low  (o_canonical_low),
        .o_took_reverse   (o_took_reverse)
    );

    kmer_recode_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_raw_high       (i_raw_high),
        .i_raw_low        (i_raw_low),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_result_valid   (o_result_valid),
        .i_recoded_high   (o_recoded_high),
        .i_recoded_low    (o_recoded_low),
        .i_canonical_high (o_canonical_high),
        .i_canonical_low  (o_canonical_low),
        .i_took_reverse   (o_took_reverse),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Leaves start high after the beat is taken; the next beat or idle cycle changes it.
    task automatic send_kmer(input t_word hi, input t_word lo);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_raw_high <= {$urandom, $urandom};
            i_raw_low  <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_raw_high <= hi;
        i_raw_low  <= lo;
        do @(posedge i_clk); while (busy);
    endtask

    // Drains the pipeline before the length changes.
    task automatic set_kmer_length(input logic [KLEN_W-1:0] k);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= KLEN_W'($urandom);
    endtask

    function automatic logic [127:0] make_kmer(input logic [KLEN_W-1:0] k);
        logic [127:0] v;
        logic [127:0] base_mask;
        logic [1:0]   b;
        int           kk;
        int           style;
        kk        = int'(k);
        style     = $urandom_range(9, 0);
        v         = {$urandom, $urandom, $urandom, $urandom};
        base_mask = (128'd1 << (2 * kk)) - 128'd1;
        if (style >= 3 && style < 7) begin
            v &= base_mask;
        end else if (style >= 7 && style < 9) begin
            // Equal to its own reverse complement where k is even; raw complement is XOR 3.
            v = '0;
            for (int i = 0; 2 * i < kk; i++) begin
                b = 2'($urandom);
                v[2*i +: 2]          = b;
                v[2*(kk-1-i) +: 2]   = b ^ 2'b11;
            end
        end else if (style == 9) begin
            case ($urandom_range(2, 0))
                0:       v[127:64] = '0;
                1:       v[127:64] = '1;
                default: v[63:0]   = '0;
            endcase
        end
        return v;
    endfunction

    initial begin
        logic [127:0]      v;
        logic [KLEN_W-1:0] k;
        logic [KLEN_W-1:0] phase_len[8];
        start       = 1'b0;
        i_raw_high  = '0;
        i_raw_low   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        idle_pct    = 0;
        phase_len   = '{6'd63, 6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd62};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Length after reset is the longest one.
        send_kmer('0, '0);
        send_kmer('1, '1);
        send_kmer({32{2'b10}}, {32{2'b10}});
        send_kmer({32{2'b01}}, {32{2'b01}});
        send_kmer({$urandom, $urandom}, {$urandom, $urandom});
        // Zero length: the reverse complement is zero, so any nonzero k-mer loses to it.
        set_kmer_length(6'd0);
        send_kmer('0, '0);
        send_kmer('0, 64'd1);
        send_kmer('1, '1);
        set_kmer_length(6'd1);
        send_kmer('0, '0);
        send_kmer('0, 64'd3);
        // AT is its own reverse complement, so the forward k-mer wins the tie.
        set_kmer_length(6'd2);
        send_kmer('0, 64'hC);
        send_kmer('0, 64'hFFFF_FFFF_FFFF_FFFC);
        send_kmer('1, 64'h6);
        set_kmer_length(6'd31);
        send_kmer('1, '1);
        send_kmer({$urandom, $urandom}, {$urandom, $urandom});
        set_kmer_length(6'd32);
        send_kmer({$urandom, $urandom}, {$urandom, $urandom});
        send_kmer('1, '0);
        send_kmer('0, '1);
        set_kmer_length(6'd63);
        send_kmer({32{2'b11}}, {32{2'b00}});

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 52;
                default: idle_pct = 11;
            endcase
            k = (phase < 8) ? phase_len[phase] : KLEN_W'($urandom_range(63, 0));
            set_kmer_length(k);
            for (int n = 0; n < 50; n++) begin
                v = make_kmer(k);
                send_kmer(v[127:64], v[63:0]);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
